FILE: sv/tmtc_pkg.sv
// Package for the tempo map transport clock: field widths, fixed-point
// constants, opcode codes, word and segment record types, control bundles.
// No dependencies.
`default_nettype none

package tmtc_pkg;

  localparam int BEAT_W = 56;
  localparam int BPM_W  = 26;
  localparam int FRM_W  = 16;
  localparam int SR_W   = 18;
  localparam int BPF_W  = 50;
  localparam int OUT_CAP = 16;
  localparam int DIVS_W = 24;

  localparam logic [BPM_W-1:0]  BPM_120   = 26'd7864320;
  localparam logic [SR_W-1:0]   SR_RESET  = 18'd48000;
  localparam logic [BEAT_W-1:0] BEAT_MAX  = {BEAT_W{1'b1}};
  localparam logic              ST_OK     = 1'b0;
  localparam logic              ST_REJECT = 1'b1;

  typedef enum logic [2:0] {
    OP_ADVANCE    = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_STOP_RESET = 3'd3,
    OP_SEEK       = 3'd4,
    OP_SET_TEMPO  = 3'd5,
    OP_SET_LOOP   = 3'd6,
    OP_CLEAR_LOOP = 3'd7
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [FRM_W-1:0]  frames;
    logic [BEAT_W-1:0] beat;
    logic [BEAT_W-1:0] end_beat;
    logic [BPM_W-1:0]  bpm;
    logic              loop_enable;
  } in_word_t;

  typedef struct packed {
    logic              status;
    logic [FRM_W-1:0]  seg_offset;
    logic [FRM_W-1:0]  seg_frames;
    logic [BEAT_W-1:0] seg_start_beat;
    logic [BEAT_W-1:0] seg_end_beat;
    logic [BPM_W-1:0]  seg_bpm;
    logic              wrapped;
    logic [BEAT_W-1:0] final_beat;
    logic              last;
  } out_word_t;

  // one stored segment awaiting the final position
  typedef struct packed {
    logic [FRM_W-1:0]  offset;
    logic [FRM_W-1:0]  frames;
    logic [BEAT_W-1:0] start_beat;
    logic [BEAT_W-1:0] end_beat;
    logic [BPM_W-1:0]  bpm;
    logic              wrapped;
  } seg_rec_t;

  typedef enum logic [4:0] {
    C_NONE,
    C_LATCH,
    C_SIMPLE,
    C_LOOP,
    C_REJECT,
    C_SCAN_RD,
    C_SCAN_NEXT,
    C_SCAN_HIT,
    C_DIV_BPF,
    C_BPF,
    C_DIV_BF,
    C_SEG,
    C_MUL_LO,
    C_MUL_HI,
    C_ADD,
    C_STEP,
    C_EMIT_RD,
    C_EMIT,
    C_EMIT_IDLE,
    C_EMIT_SETUP,
    C_TB_SET,
    C_INS_START,
    C_INS_RD,
    C_INS_SHIFT,
    C_INS_PUT
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    advance_go;
    logic    bpm_zero;
    logic    idx_end;
    logic    scan_hit;
    logic    match_hit;
    logic    full;
    logic    ins_zero;
    logic    ins_gt;
    logic    has_div2;
    logic    div_done;
    logic    rem_last;
    logic    emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/tmtc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tmtc_pkg for the operand width.
`default_nettype none

module tmtc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tmtc_pkg::BEAT_W-1:0] dividend,
  input  wire logic [tmtc_pkg::BEAT_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [tmtc_pkg::BEAT_W-1:0]     quot,
  output logic [tmtc_pkg::BEAT_W-1:0]     rmd
);

  localparam int W  = tmtc_pkg::BEAT_W;
  localparam int CW = $clog2(W);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  q_r, r_r, dvs_r;
  logic [W:0]    r_sh;
  logic          fits;

  assign r_sh = {r_r, q_r[W-1]};
  assign fits = r_sh >= {1'b0, dvs_r};

  // control: count the bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        r_r <= W'(r_sh - {1'b0, dvs_r});
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= r_sh[W-1:0];
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rmd  = r_r;

endmodule

`default_nettype wire

FILE: sv/tmtc_dp.sv
// Datapath: transport state, tempo map memory, segment buffer, shared
// divider, split multiplier and result register. Depends on tmtc_pkg, tmtc_div.
`default_nettype none

module tmtc_dp #(
  parameter int TEMPO_ENTRIES = 16,
  parameter int MAX_SEGMENTS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tmtc_pkg::dp_cmd_t       cmd,
  input  wire tmtc_pkg::in_word_t      in_word,
  input  wire logic                    cfg_we,
  input  wire logic [tmtc_pkg::SR_W-1:0] cfg_wdata,
  output tmtc_pkg::dp_stat_t           stat,
  output logic                         out_strobe,
  output tmtc_pkg::out_word_t          out_word
);

  localparam int BW   = tmtc_pkg::BEAT_W;
  localparam int PW   = tmtc_pkg::BPM_W;
  localparam int FW   = tmtc_pkg::FRM_W;
  localparam int QW   = tmtc_pkg::BPF_W;
  localparam int HW   = QW / 2;
  localparam int AW   = $clog2(TEMPO_ENTRIES);
  localparam int CW   = $clog2(TEMPO_ENTRIES + 1);
  localparam int CAP  = (MAX_SEGMENTS < tmtc_pkg::OUT_CAP) ? MAX_SEGMENTS : tmtc_pkg::OUT_CAP;
  localparam int NW   = $clog2(CAP + 1);
  localparam int BAW  = (CAP > 1) ? $clog2(CAP) : 1;

  // transport state
  tmtc_pkg::in_word_t in_r;
  logic [tmtc_pkg::SR_W-1:0] sr_r;
  logic [BW-1:0] pos_r, loop_start_r, loop_end_r, start_r, nbt_r;
  logic          running_r, loop_on_r, found_r, wr_r, status_r;
  logic [CW-1:0] count_r, idx_r;
  logic [PW-1:0] tv_r;
  logic [QW-1:0] bpf_r;
  logic [FW-1:0] rem_r, seg_r;
  logic [FW+HW-1:0] plo_r, phi_r;
  logic [NW-1:0] n_r, k_r;
  logic          e0_set_r;

  // tempo map memory
  logic [BW-1:0] tb_beat_m [TEMPO_ENTRIES];
  logic [PW-1:0] tb_val_m  [TEMPO_ENTRIES];
  logic [BW-1:0] tb_rbeat_q;
  logic [PW-1:0] tb_rval_q;
  logic [AW-1:0] tb_raddr, tb_raddr_q, tb_waddr;
  logic          tb_we;
  logic [BW-1:0] tb_wbeat, rd_beat;
  logic [PW-1:0] tb_wval, rd_val;

  // segment buffer
  tmtc_pkg::seg_rec_t seg_mem [CAP];
  tmtc_pkg::seg_rec_t seg_q;

  // divider hookup
  logic          div_start, div_busy, div_done;
  logic [BW-1:0] div_dvd, div_dvs, div_q, div_r;
  logic [tmtc_pkg::SR_W-1:0]   sr_eff;
  logic [tmtc_pkg::DIVS_W-1:0] div60;

  // combinational helpers
  logic          has_nb, has_div2, wrap_now;
  logic [BW-1:0] nb;
  logic [BW:0]   bf;
  logic [FW+QW-1:0] inc;
  logic [BW+FW+QW-BW:0] sum;

  // frames per second times sixty
  assign sr_eff = (sr_r == '0) ? tmtc_pkg::SR_W'(1) : sr_r;
  assign div60  = (tmtc_pkg::DIVS_W'(sr_eff) << 6) - (tmtc_pkg::DIVS_W'(sr_eff) << 2);

  // next boundary: nearest of next tempo change and loop end
  assign has_nb   = loop_on_r | found_r;
  assign nb       = !loop_on_r ? nbt_r :
                    (found_r && (nbt_r < loop_end_r)) ? nbt_r : loop_end_r;
  assign has_div2 = has_nb && (nb > pos_r);
  assign wrap_now = loop_on_r && (pos_r >= loop_end_r);

  assign bf  = (BW + 1)'(div_q) + (BW + 1)'(div_r != '0);
  assign inc = ((FW + QW)'(phi_r) << HW) + (FW + QW)'(plo_r);
  assign sum = ($bits(sum))'(pos_r) + ($bits(sum))'(inc);

  assign div_start = (cmd == tmtc_pkg::C_DIV_BPF) || (cmd == tmtc_pkg::C_DIV_BF);
  assign div_dvd   = (cmd == tmtc_pkg::C_DIV_BPF) ? BW'({tv_r, 24'd0}) : (nb - pos_r);
  assign div_dvs   = (cmd == tmtc_pkg::C_DIV_BPF) ? BW'(div60) : BW'(bpf_r);

  tmtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rmd      (div_r)
  );

  // tempo map read: entry zero reads its reset value until first written
  assign tb_raddr = (cmd == tmtc_pkg::C_INS_RD) ? (idx_r[AW-1:0] - AW'(1)) : idx_r[AW-1:0];
  assign rd_beat  = (tb_raddr_q == '0 && !e0_set_r) ? '0 : tb_rbeat_q;
  assign rd_val   = (tb_raddr_q == '0 && !e0_set_r) ? tmtc_pkg::BPM_120 : tb_rval_q;

  always_comb begin
    tb_we    = 1'b0;
    tb_waddr = idx_r[AW-1:0];
    tb_wbeat = in_r.beat;
    tb_wval  = in_r.bpm;
    case (cmd)
      tmtc_pkg::C_TB_SET, tmtc_pkg::C_INS_PUT: tb_we = 1'b1;
      tmtc_pkg::C_INS_SHIFT: begin
        tb_we    = 1'b1;
        tb_wbeat = rd_beat;
        tb_wval  = rd_val;
      end
      default: tb_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tb_beat_m[tb_waddr] <= tb_wbeat;
      tb_val_m[tb_waddr]  <= tb_wval;
    end
    tb_rbeat_q <= tb_beat_m[tb_raddr];
    tb_rval_q  <= tb_val_m[tb_raddr];
    tb_raddr_q <= tb_raddr;
  end

  // segment buffer write on each step while below capacity, read for emission
  always_ff @(posedge clk) begin
    if (cmd == tmtc_pkg::C_STEP && n_r < NW'(CAP)) begin
      seg_mem[n_r[BAW-1:0]] <= '{offset: in_r.frames - rem_r, frames: seg_r,
                                 start_beat: start_r, end_beat: pos_r,
                                 bpm: tv_r, wrapped: wr_r | wrap_now};
    end
    if (cmd == tmtc_pkg::C_EMIT_RD) begin
      seg_q <= seg_mem[k_r[BAW-1:0]];
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r         <= tmtc_pkg::SR_RESET;
      pos_r        <= '0;
      running_r    <= 1'b0;
      loop_start_r <= '0;
      loop_end_r   <= '0;
      loop_on_r    <= 1'b0;
      count_r      <= CW'(1);
      e0_set_r     <= 1'b0;
      idx_r        <= '0;
      found_r      <= 1'b0;
      n_r          <= '0;
      k_r          <= '0;
      wr_r         <= 1'b0;
      status_r     <= tmtc_pkg::ST_OK;
      out_strobe   <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_we) sr_r <= cfg_wdata;
      if (tb_we && tb_waddr == '0) e0_set_r <= 1'b1;
      case (cmd)
        tmtc_pkg::C_LATCH: begin
          idx_r    <= '0;
          found_r  <= 1'b0;
          n_r      <= '0;
          k_r      <= '0;
          wr_r     <= 1'b0;
          status_r <= tmtc_pkg::ST_OK;
        end
        tmtc_pkg::C_SIMPLE: begin
          case (in_r.opcode)
            tmtc_pkg::OP_START: running_r <= 1'b1;
            tmtc_pkg::OP_STOP:  running_r <= 1'b0;
            tmtc_pkg::OP_STOP_RESET: begin
              running_r <= 1'b0;
              pos_r     <= '0;
            end
            tmtc_pkg::OP_SEEK:       pos_r     <= in_r.beat;
            tmtc_pkg::OP_CLEAR_LOOP: loop_on_r <= 1'b0;
            default: running_r <= running_r;
          endcase
        end
        tmtc_pkg::C_LOOP: begin
          if (in_r.end_beat <= in_r.beat) begin
            status_r <= tmtc_pkg::ST_REJECT;
          end else begin
            loop_start_r <= in_r.beat;
            loop_end_r   <= in_r.end_beat;
            loop_on_r    <= in_r.loop_enable;
            if (pos_r >= in_r.end_beat) pos_r <= in_r.beat;
          end
        end
        tmtc_pkg::C_REJECT:    status_r <= tmtc_pkg::ST_REJECT;
        tmtc_pkg::C_SCAN_NEXT: idx_r <= idx_r + CW'(1);
        tmtc_pkg::C_SCAN_HIT: begin
          found_r <= 1'b1;
        end
        tmtc_pkg::C_STEP: begin
          if (wrap_now) begin
            pos_r <= loop_start_r;
            wr_r  <= 1'b1;
          end
          if (n_r < NW'(CAP)) n_r <= n_r + NW'(1);
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        tmtc_pkg::C_ADD: pos_r <= (sum > ($bits(sum))'(tmtc_pkg::BEAT_MAX)) ?
                                  tmtc_pkg::BEAT_MAX : sum[BW-1:0];
        tmtc_pkg::C_INS_START: idx_r <= count_r;
        tmtc_pkg::C_INS_SHIFT: idx_r <= idx_r - CW'(1);
        tmtc_pkg::C_INS_PUT:   count_r <= count_r + CW'(1);
        tmtc_pkg::C_EMIT: begin
          k_r        <= k_r + NW'(1);
          out_strobe <= 1'b1;
        end
        tmtc_pkg::C_EMIT_IDLE, tmtc_pkg::C_EMIT_SETUP: out_strobe <= 1'b1;
        default: idx_r <= idx_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      tmtc_pkg::C_LATCH: begin
        in_r  <= in_word;
        rem_r <= in_word.frames;
      end
      tmtc_pkg::C_SCAN_NEXT: tv_r  <= rd_val;
      tmtc_pkg::C_SCAN_HIT:  nbt_r <= rd_beat;
      tmtc_pkg::C_BPF: bpf_r <= (div_q == '0) ? QW'(1) : div_q[QW-1:0];
      tmtc_pkg::C_SEG: begin
        if (!has_nb) seg_r <= rem_r;
        else if (has_div2) seg_r <= (bf < (BW + 1)'(rem_r)) ? bf[FW-1:0] : rem_r;
        else seg_r <= FW'(1);
      end
      tmtc_pkg::C_MUL_LO: plo_r <= (FW + HW)'(seg_r) * (FW + HW)'(bpf_r[HW-1:0]);
      tmtc_pkg::C_MUL_HI: phi_r <= (FW + HW)'(seg_r) * (FW + HW)'(bpf_r[QW-1:HW]);
      tmtc_pkg::C_ADD:    start_r <= pos_r;
      tmtc_pkg::C_STEP:   rem_r <= rem_r - seg_r;
      tmtc_pkg::C_EMIT: begin
        out_word <= '{status: tmtc_pkg::ST_OK, seg_offset: seg_q.offset,
                      seg_frames: seg_q.frames, seg_start_beat: seg_q.start_beat,
                      seg_end_beat: seg_q.end_beat, seg_bpm: seg_q.bpm,
                      wrapped: seg_q.wrapped, final_beat: pos_r,
                      last: stat.emit_last};
      end
      tmtc_pkg::C_EMIT_IDLE: begin
        out_word <= '{status: tmtc_pkg::ST_OK, seg_offset: '0, seg_frames: '0,
                      seg_start_beat: pos_r, seg_end_beat: pos_r, seg_bpm: tv_r,
                      wrapped: 1'b0, final_beat: pos_r, last: 1'b1};
      end
      tmtc_pkg::C_EMIT_SETUP: begin
        out_word <= '{status: status_r, seg_offset: '0, seg_frames: '0,
                      seg_start_beat: '0, seg_end_beat: '0, seg_bpm: '0,
                      wrapped: 1'b0, final_beat: pos_r, last: 1'b1};
      end
      default: rem_r <= rem_r;
    endcase
  end

  // status to the controller
  always_comb begin
    stat.op         = in_r.opcode;
    stat.advance_go = running_r && (in_r.frames != '0);
    stat.bpm_zero   = (in_r.bpm == '0);
    stat.idx_end    = (idx_r == count_r);
    stat.scan_hit   = (rd_beat > pos_r);
    stat.match_hit  = (rd_beat == in_r.beat);
    stat.full       = (count_r >= CW'(TEMPO_ENTRIES));
    stat.ins_zero   = (idx_r == '0);
    stat.ins_gt     = (rd_beat > in_r.beat);
    stat.has_div2   = has_div2;
    stat.div_done   = div_done;
    stat.rem_last   = (rem_r == seg_r);
    stat.emit_last  = ((k_r + NW'(1)) == n_r);
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(TEMPO_ENTRIES)))
    else $error("tempo map count out of range");

  a_seg_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(CAP))
    else $error("segment buffer count beyond capacity");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on two cycles in a row");

endmodule

`default_nettype wire

FILE: sv/tmtc_ctrl.sv
// Controller state machine: sequences scans of the tempo map, divisions,
// segment steps and result emission. Depends on tmtc_pkg.
`default_nettype none

module tmtc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tmtc_pkg::dp_stat_t  stat,
  output tmtc_pkg::dp_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SC_RD, S_SC_CHK, S_SC_END, S_DV1, S_BF_CHK, S_DV2,
    S_MUL1, S_MUL2, S_ADD, S_STEP, S_EM_RD, S_EM_OUT, S_MT_RD, S_MT_CHK,
    S_INS_RD, S_INS_CHK, S_OUT_SETUP
  } state_t;

  state_t state_r, state_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = tmtc_pkg::C_NONE;
    case (state_r)
      S_IDLE: if (start) begin
        cmd       = tmtc_pkg::C_LATCH;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          tmtc_pkg::OP_ADVANCE: state_nxt = S_SC_RD;
          tmtc_pkg::OP_SET_TEMPO: begin
            if (stat.bpm_zero) begin
              cmd       = tmtc_pkg::C_REJECT;
              state_nxt = S_OUT_SETUP;
            end else begin
              state_nxt = S_MT_RD;
            end
          end
          tmtc_pkg::OP_SET_LOOP: begin
            cmd       = tmtc_pkg::C_LOOP;
            state_nxt = S_OUT_SETUP;
          end
          default: begin
            cmd       = tmtc_pkg::C_SIMPLE;
            state_nxt = S_OUT_SETUP;
          end
        endcase
      end
      // walk the map for the tempo in force and the next change
      S_SC_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_SC_END;
        end else begin
          cmd       = tmtc_pkg::C_SCAN_RD;
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (stat.scan_hit) begin
          cmd       = tmtc_pkg::C_SCAN_HIT;
          state_nxt = S_SC_END;
        end else begin
          cmd       = tmtc_pkg::C_SCAN_NEXT;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_END: begin
        if (!stat.advance_go) begin
          cmd       = tmtc_pkg::C_EMIT_IDLE;
          state_nxt = S_IDLE;
        end else begin
          cmd       = tmtc_pkg::C_DIV_BPF;
          state_nxt = S_DV1;
        end
      end
      S_DV1: if (stat.div_done) begin
        cmd       = tmtc_pkg::C_BPF;
        state_nxt = S_BF_CHK;
      end
      S_BF_CHK: begin
        if (stat.has_div2) begin
          cmd       = tmtc_pkg::C_DIV_BF;
          state_nxt = S_DV2;
        end else begin
          cmd       = tmtc_pkg::C_SEG;
          state_nxt = S_MUL1;
        end
      end
      S_DV2: if (stat.div_done) begin
        cmd       = tmtc_pkg::C_SEG;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd       = tmtc_pkg::C_MUL_LO;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd       = tmtc_pkg::C_MUL_HI;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd       = tmtc_pkg::C_ADD;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd       = tmtc_pkg::C_STEP;
        state_nxt = stat.rem_last ? S_EM_RD : S_SC_RD;
      end
      // drain the stored segments
      S_EM_RD: begin
        cmd       = tmtc_pkg::C_EMIT_RD;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd       = tmtc_pkg::C_EMIT;
        state_nxt = stat.emit_last ? S_IDLE : S_EM_RD;
      end
      // set tempo: look for the same beat, else insert in order
      S_MT_RD: begin
        if (stat.idx_end) begin
          if (stat.full) begin
            cmd       = tmtc_pkg::C_REJECT;
            state_nxt = S_OUT_SETUP;
          end else begin
            cmd       = tmtc_pkg::C_INS_START;
            state_nxt = S_INS_RD;
          end
        end else begin
          cmd       = tmtc_pkg::C_SCAN_RD;
          state_nxt = S_MT_CHK;
        end
      end
      S_MT_CHK: begin
        if (stat.match_hit) begin
          cmd       = tmtc_pkg::C_TB_SET;
          state_nxt = S_OUT_SETUP;
        end else begin
          cmd       = tmtc_pkg::C_SCAN_NEXT;
          state_nxt = S_MT_RD;
        end
      end
      S_INS_RD: begin
        if (stat.ins_zero) begin
          cmd       = tmtc_pkg::C_INS_PUT;
          state_nxt = S_OUT_SETUP;
        end else begin
          cmd       = tmtc_pkg::C_INS_RD;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat.ins_gt) begin
          cmd       = tmtc_pkg::C_INS_SHIFT;
          state_nxt = S_INS_RD;
        end else begin
          cmd       = tmtc_pkg::C_INS_PUT;
          state_nxt = S_OUT_SETUP;
        end
      end
      S_OUT_SETUP: begin
        cmd       = tmtc_pkg::C_EMIT_SETUP;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DV1) && !stat.div_done) |=> (state_r == S_DV1))
    else $error("left divide wait early");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EM_OUT) && stat.emit_last) |=> (state_r == S_IDLE))
    else $error("emission did not end on last word");

endmodule

`default_nettype wire

FILE: sv/tempo_map_transport_clock_top.sv
// Top level of the tempo map transport clock: controller plus datapath.
// Depends on tmtc_pkg, tmtc_ctrl, tmtc_dp, tmtc_div.
//
//   channel   ports                      accepted when
//   input     start, busy, in_word       start high and busy low
//   result    out_strobe, out_word       every cycle out_strobe is high
//   config    cfg_we, cfg_wdata          every cycle cfg_we is high
//
// A set-up word passes from decode to a result set-up state that registers its
// single result word; set tempo first searches the map entry by entry and, if no
// entry matches, shifts entries to insert. An advance, per segment, scans the map
// entries, then makes two waits on the shared 56-step divider (beats per frame,
// then frames to the boundary, skipped when no boundary lies ahead), multiplies
// in two halves, adds and steps; then each stored segment is read and emitted.
// Reset (rst_n low, synchronous) clears the transport, the loop and the map
// to one entry of 120 bpm at beat zero; no clearing pass is needed.
// Result words cannot be stalled; each is shown for one cycle only.
`default_nettype none

module tempo_map_transport_clock_top #(
  parameter int MAX_SEGMENTS  = 16,
  parameter int TEMPO_ENTRIES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire tmtc_pkg::in_word_t        in_word,
  output logic                           out_strobe,
  output tmtc_pkg::out_word_t            out_word,
  input  wire logic                      cfg_we,
  input  wire logic [tmtc_pkg::SR_W-1:0] cfg_wdata
);

  tmtc_pkg::dp_cmd_t  cmd;
  tmtc_pkg::dp_stat_t stat;

  tmtc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tmtc_dp #(
    .TEMPO_ENTRIES (TEMPO_ENTRIES),
    .MAX_SEGMENTS  (MAX_SEGMENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

FILE: tb/tb_tempo_map_transport_clock_top.sv
// Testbench for the tempo map transport clock: a directed table, then random
// command words over several sample rates, all checked against a predictor.
// Depends on tmtc_pkg and tempo_map_transport_clock_top.
`timescale 1ns / 1ps

module tb_tempo_map_transport_clock_top;

  typedef tmtc_pkg::in_word_t  in_word_t;
  typedef tmtc_pkg::out_word_t out_word_t;
  typedef tmtc_pkg::opcode_t   opcode_t;

  localparam int BEAT_W = tmtc_pkg::BEAT_W;
  localparam int BPM_W  = tmtc_pkg::BPM_W;
  localparam int FRM_W  = tmtc_pkg::FRM_W;
  localparam int SR_W   = tmtc_pkg::SR_W;
  localparam logic [BPM_W-1:0]  BPM_120   = tmtc_pkg::BPM_120;
  localparam logic [SR_W-1:0]   SR_RESET  = tmtc_pkg::SR_RESET;
  localparam logic [BEAT_W-1:0] BEAT_MAX  = tmtc_pkg::BEAT_MAX;
  localparam logic              ST_OK     = tmtc_pkg::ST_OK;
  localparam logic              ST_REJECT = tmtc_pkg::ST_REJECT;

  localparam int WATCHDOG_LIMIT = 500000;
  localparam int SEG_CAP = 16;
  localparam int MAP_SIZE = 16;
  localparam logic [63:0] BEAT_ONE = 64'd1 << 40;

  typedef struct {
    in_word_t          w;
    bit                has_exp;
    logic              exp_status;
    logic [BEAT_W-1:0] exp_final;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_strobe;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [SR_W-1:0] cfg_wdata = '0;

  // transport state as predicted
  logic [63:0] tr_pos;
  bit tr_running;
  logic [63:0] map_beat [MAP_SIZE];
  logic [BPM_W-1:0] map_bpm [MAP_SIZE];
  int map_count;
  logic [63:0] lp_start, lp_end;
  bit lp_on;
  logic [SR_W-1:0] rate;

  out_word_t pending_q[$];
  int fails = 0;
  int words_sent = 0;
  int words_seen = 0;
  int idle_cnt = 0;
  int gap_pct = 0;
  table_row_t dir_tab[$];

  tempo_map_transport_clock_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [BPM_W-1:0] tempo_at(logic [63:0] b);
    logic [BPM_W-1:0] v;
    v = map_bpm[0];
    for (int i = 0; i < map_count; i++) begin
      if (map_beat[i] > b) break;
      v = map_bpm[i];
    end
    return v;
  endfunction

  // replace a matching beat, else insert in order; reject zero and a full map
  function automatic logic insert_tempo(logic [BPM_W-1:0] bpm, logic [63:0] b);
    int j;
    if (bpm == 0) return ST_REJECT;
    for (int i = 0; i < map_count; i++) begin
      if (map_beat[i] == b) begin
        map_bpm[i] = bpm;
        return ST_OK;
      end
    end
    if (map_count >= MAP_SIZE) return ST_REJECT;
    j = map_count;
    while (j > 0 && map_beat[j-1] > b) begin
      map_beat[j] = map_beat[j-1];
      map_bpm[j] = map_bpm[j-1];
      j--;
    end
    map_beat[j] = b;
    map_bpm[j] = bpm;
    map_count++;
    return ST_OK;
  endfunction

  function automatic void reset_transport();
    tr_pos = 0;
    tr_running = 0;
    for (int i = 0; i < MAP_SIZE; i++) begin
      map_beat[i] = 0;
      map_bpm[i] = 0;
    end
    map_bpm[0] = BPM_120;
    map_count = 1;
    lp_start = 0;
    lp_end = 0;
    lp_on = 0;
    rate = SR_RESET;
  endfunction

  // work out the result words of one command word and queue them
  function automatic void predict_words(in_word_t w);
    out_word_t segs[$];
    out_word_t r;
    logic [63:0] rem, sr, bpf, nb, d, bf, seg, first, inc;
    logic [BPM_W-1:0] b;
    bit has, wr;
    logic st;
    r = '0;
    st = ST_OK;
    if (w.opcode == tmtc_pkg::OP_ADVANCE) begin
      if (tr_running && w.frames != 0) begin
        sr = (rate == 0) ? 64'd1 : 64'(rate);
        rem = 64'(w.frames);
        wr = 0;
        while (rem > 0) begin
          b = tempo_at(tr_pos);
          bpf = (64'(b) << 24) / (64'd60 * sr);
          if (bpf == 0) bpf = 1;
          has = lp_on;
          nb = lp_end;
          for (int i = 0; i < map_count; i++) begin
            if (map_beat[i] > tr_pos) begin
              if (!has || map_beat[i] < nb) nb = map_beat[i];
              has = 1;
              break;
            end
          end
          if (has) begin
            bf = 1;
            if (nb > tr_pos) begin
              d = nb - tr_pos;
              bf = d / bpf + ((d % bpf) != 0 ? 64'd1 : 64'd0);
              if (bf == 0) bf = 1;
            end
            seg = (bf < rem) ? bf : rem;
          end else begin
            seg = rem;
          end
          first = tr_pos;
          inc = seg * bpf;
          tr_pos = (inc > 64'(BEAT_MAX) - tr_pos) ? 64'(BEAT_MAX) : tr_pos + inc;
          r = '0;
          r.seg_offset = 16'(64'(w.frames) - rem);
          r.seg_frames = 16'(seg);
          r.seg_start_beat = first[BEAT_W-1:0];
          r.seg_end_beat = tr_pos[BEAT_W-1:0];
          r.seg_bpm = b;
          rem -= seg;
          if (lp_on && tr_pos >= lp_end) begin
            tr_pos = lp_start;
            wr = 1;
          end
          r.wrapped = wr;
          // drop segments past the cap, but keep advancing
          if (segs.size() < SEG_CAP) segs = {segs, r};
        end
        foreach (segs[k]) begin
          segs[k].final_beat = tr_pos[BEAT_W-1:0];
          segs[k].last = (k == segs.size() - 1);
          pending_q = {pending_q, segs[k]};
        end
        return;
      end
      r.seg_start_beat = tr_pos[BEAT_W-1:0];
      r.seg_end_beat = tr_pos[BEAT_W-1:0];
      r.seg_bpm = tempo_at(tr_pos);
    end else begin
      case (w.opcode)
        tmtc_pkg::OP_START: tr_running = 1;
        tmtc_pkg::OP_STOP: tr_running = 0;
        tmtc_pkg::OP_STOP_RESET: begin
          tr_running = 0;
          tr_pos = 0;
        end
        tmtc_pkg::OP_SEEK: tr_pos = 64'(w.beat);
        tmtc_pkg::OP_SET_TEMPO: st = insert_tempo(w.bpm, 64'(w.beat));
        tmtc_pkg::OP_SET_LOOP: begin
          if (w.end_beat <= w.beat) begin
            st = ST_REJECT;
          end else begin
            lp_start = 64'(w.beat);
            lp_end = 64'(w.end_beat);
            lp_on = w.loop_enable;
            if (tr_pos >= lp_end) tr_pos = lp_start;
          end
        end
        default: lp_on = 0;
      endcase
    end
    r.status = st;
    r.final_beat = tr_pos[BEAT_W-1:0];
    r.last = 1'b1;
    pending_q = {pending_q, r};
  endfunction

  function automatic in_word_t mk(opcode_t op, logic [FRM_W-1:0] fr, logic [63:0] bt,
                                  logic [63:0] eb, logic [BPM_W-1:0] bpm, logic le);
    in_word_t w;
    w.opcode = op;
    w.frames = fr;
    w.beat = bt[BEAT_W-1:0];
    w.end_beat = eb[BEAT_W-1:0];
    w.bpm = bpm;
    w.loop_enable = le;
    return w;
  endfunction

  function automatic void add_row(in_word_t w, bit has_exp = 0, logic st = ST_OK,
                                  logic [63:0] fin = 0);
    table_row_t t;
    t.w = w;
    t.has_exp = has_exp;
    t.exp_status = st;
    t.exp_final = fin[BEAT_W-1:0];
    dir_tab = {dir_tab, t};
  endfunction

  function automatic logic [63:0] near_beat();
    if ($urandom_range(99) < 85) return {20'd0, 12'($urandom_range(4095)), $urandom};
    return {$urandom, $urandom};
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    logic [63:0] b;
    w = '0;
    w.beat = BEAT_W'(near_beat());
    w.end_beat = BEAT_W'({$urandom, $urandom});
    w.bpm = BPM_W'($urandom);
    w.loop_enable = 1'($urandom_range(1));
    // keep long advances to rates where the segment count stays modest
    if (rate < 1000) w.frames = FRM_W'($urandom_range(64));
    else if ($urandom_range(99) < 90) w.frames = FRM_W'($urandom_range(4000));
    else w.frames = ($urandom_range(1) != 0) ? 16'hFFFF : FRM_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) w.opcode = tmtc_pkg::OP_ADVANCE;
    else if (pick < 55) w.opcode = tmtc_pkg::OP_START;
    else if (pick < 60) w.opcode = tmtc_pkg::OP_STOP;
    else if (pick < 63) w.opcode = tmtc_pkg::OP_STOP_RESET;
    else if (pick < 71) w.opcode = tmtc_pkg::OP_SEEK;
    else if (pick < 87) w.opcode = tmtc_pkg::OP_SET_TEMPO;
    else if (pick < 97) w.opcode = tmtc_pkg::OP_SET_LOOP;
    else w.opcode = tmtc_pkg::OP_CLEAR_LOOP;
    if (w.opcode == tmtc_pkg::OP_SET_TEMPO) begin
      pick = $urandom_range(99);
      if (pick < 5) w.bpm = 0;
      else if (pick < 85) w.bpm = BPM_W'($urandom_range(400 << 16, 20 << 16));
    end
    if (w.opcode == tmtc_pkg::OP_SET_LOOP) begin
      pick = $urandom_range(99);
      b = 64'(w.beat);
      if (pick < 10) w.end_beat = w.beat - BEAT_W'($urandom_range(1));
      else if (pick < 85 && b < 64'(BEAT_MAX) - (64'd1 << 45))
        w.end_beat = BEAT_W'(b + (64'd1 << 36) +
                             {20'd0, 12'($urandom_range(4095)), $urandom});
    end
    return w;
  endfunction

  // present one word, holding it until the block takes it
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    in_word <= w;
    do @(negedge clk); while (busy);
    @(posedge clk);
    predict_words(w);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_rate(logic [SR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate = v;
  endtask

  task automatic chk(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fails++;
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_strobe) begin
      words_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = pending_q.pop_front();
        chk("status", 64'(e.status), 64'(out_word.status));
        chk("seg_offset", 64'(e.seg_offset), 64'(out_word.seg_offset));
        chk("seg_frames", 64'(e.seg_frames), 64'(out_word.seg_frames));
        chk("seg_start_beat", 64'(e.seg_start_beat), 64'(out_word.seg_start_beat));
        chk("seg_end_beat", 64'(e.seg_end_beat), 64'(out_word.seg_end_beat));
        chk("seg_bpm", 64'(e.seg_bpm), 64'(out_word.seg_bpm));
        chk("wrapped", 64'(e.wrapped), 64'(out_word.wrapped));
        chk("final_beat", 64'(e.final_beat), 64'(out_word.final_beat));
        chk("last", 64'(e.last), 64'(out_word.last));
      end
    end
  end

  // stop a hung run: count cycles with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [SR_W-1:0] rates [6];
    int pcts [6];
    reset_transport();
    rates = '{SR_RESET, 18'd1, 18'h3FFFF, 18'd0, 18'd192000, 18'd44100};
    pcts = '{0, 57, 31, 0, 57, 31};

    // directed: reset view, rejects, extremes, map edits, loop cases, saturation
    add_row(mk(tmtc_pkg::OP_ADVANCE, 100, 0, 0, 0, 0), 1, ST_OK, 0);
    add_row(mk(tmtc_pkg::OP_SET_TEMPO, 0, 5, 0, 0, 0), 1, ST_REJECT, 0);
    add_row(mk(tmtc_pkg::OP_SET_LOOP, 0, 10, 10, 0, 1), 1, ST_REJECT, 0);
    add_row(mk(tmtc_pkg::OP_SEEK, 0, 64'(BEAT_MAX), 0, 0, 0), 1, ST_OK, 64'(BEAT_MAX));
    add_row(mk(tmtc_pkg::OP_STOP_RESET, 0, 0, 0, 0, 0), 1, ST_OK, 0);
    add_row(mk(tmtc_pkg::OP_START, 0, 0, 0, 0, 0), 1, ST_OK, 0);
    add_row(mk(tmtc_pkg::OP_ADVANCE, 0, 0, 0, 0, 0), 1, ST_OK, 0);
    add_row(mk(tmtc_pkg::OP_ADVANCE, 480, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_SET_TEMPO, 0, BEAT_ONE, 0, 26'(60 << 16), 0));
    add_row(mk(tmtc_pkg::OP_SET_TEMPO, 0, BEAT_ONE, 0, 26'(90 << 16), 0));
    add_row(mk(tmtc_pkg::OP_SET_TEMPO, 0, 2 * BEAT_ONE, 0, 26'h3FFFFFF, 0));
    add_row(mk(tmtc_pkg::OP_ADVANCE, 48000, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_SEEK, 0, 0, 0, 0, 0), 1, ST_OK, 0);
    add_row(mk(tmtc_pkg::OP_SET_LOOP, 0, 0, 64'd1 << 36, 0, 1));
    add_row(mk(tmtc_pkg::OP_ADVANCE, 16'hFFFF, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_SEEK, 0, 5 * BEAT_ONE, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_ADVANCE, 10, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_SET_LOOP, 0, 3 * BEAT_ONE, 4 * BEAT_ONE, 0, 0));
    add_row(mk(tmtc_pkg::OP_CLEAR_LOOP, 0, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_SEEK, 0, 64'(BEAT_MAX) - 100, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_ADVANCE, 1000, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_STOP, 0, 0, 0, 0, 0));
    add_row(mk(tmtc_pkg::OP_ADVANCE, 5, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].w);
      if (dir_tab[i].has_exp) begin
        if (pending_q[$].status !== dir_tab[i].exp_status ||
            pending_q[$].final_beat !== dir_tab[i].exp_final) begin
          $error("row %0d: table expects status %0h final %0h", i,
                 dir_tab[i].exp_status, dir_tab[i].exp_final);
          fails++;
        end
      end
    end

    // random phases, each at its own rate and gap percentage, drained in between
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p > 0) write_rate(rates[p]);
      gap_pct = pcts[p];
      repeat (18) send_word(random_word());
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d command words sent, %0d result words checked, 6 sample rates",
             words_sent, words_seen);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
